### src/alpd_pkg.sv
`timescale 1ns / 1ps

package alpd_pkg;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_LEN  = 2'd1,
    MODE_SKIP = 2'd2,
    MODE_DATA = 2'd3
  } mode_t;

  localparam logic [7:0] OPEN_CH  = 8'h5B;
  localparam logic [7:0] CLOSE_CH = 8'h5D;
  localparam logic [7:0] ZERO_CH  = 8'h30;
  localparam logic [7:0] NINE_CH  = 8'h39;

  localparam int unsigned LEN_W = 10;
  localparam logic [LEN_W-1:0] LEN_MAX = 10'd1023;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic             result_kind;
    logic [7:0]       payload;
    logic [LEN_W-1:0] frame_length;
    logic             last;
  } res_t;

endpackage

### src/alpd_byte_if.sv
`timescale 1ns / 1ps

interface alpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

### src/alpd_res_if.sv
`timescale 1ns / 1ps

interface alpd_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload;
  logic [9:0] frame_length;
  logic       last;

  modport source (output valid, output result_kind, output payload,
                  output frame_length, output last, input ready);
  modport sink (input valid, input result_kind, input payload,
                input frame_length, input last, output ready);
endinterface

### src/alpd_step.sv
`timescale 1ns / 1ps

module alpd_step #(
  parameter int LENGTH_DIGITS = 3,
  parameter int CNT_W = 2
) (
  input  alpd_pkg::mode_t         mode,
  input  logic [9:0]              accum,
  input  logic [CNT_W-1:0]        cnt,
  input  logic                    stopped,
  input  logic [9:0]              remaining,
  input  logic [7:0]              data_byte,
  output alpd_pkg::mode_t         mode_nxt,
  output logic [9:0]              accum_nxt,
  output logic [CNT_W-1:0]        cnt_nxt,
  output logic                    stopped_nxt,
  output logic [9:0]              remaining_nxt,
  output logic                    res_valid,
  output alpd_pkg::res_t          res
);
  import alpd_pkg::*;

  logic        is_open;
  logic        is_close;
  logic        is_digit;
  logic [13:0] scaled;
  logic [13:0] sum;
  logic [9:0]  sat;
  logic [9:0]  rem_dec;

  assign is_open  = (data_byte == OPEN_CH);
  assign is_close = (data_byte == CLOSE_CH);
  assign is_digit = (data_byte >= ZERO_CH) && (data_byte <= NINE_CH);
  assign scaled   = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0};
  assign sum      = scaled + {10'd0, data_byte[3:0]};
  assign sat      = (sum > {4'd0, LEN_MAX}) ? LEN_MAX : sum[9:0];
  assign rem_dec  = (remaining != 10'd0) ? (remaining - 10'd1) : remaining;

  always_comb begin
    mode_nxt      = mode;
    accum_nxt     = accum;
    cnt_nxt       = cnt;
    stopped_nxt   = stopped;
    remaining_nxt = remaining;
    res_valid     = 1'b0;
    res           = '0;
    unique case (mode)
      MODE_HUNT: begin
        if (is_open) begin
          mode_nxt      = MODE_LEN;
          accum_nxt     = '0;
          cnt_nxt       = '0;
          stopped_nxt   = 1'b0;
          remaining_nxt = '0;
        end
      end
      MODE_LEN: begin
        if (is_close) begin
          remaining_nxt    = accum;
          mode_nxt         = MODE_SKIP;
          res_valid        = 1'b1;
          res.result_kind  = KIND_START;
          res.frame_length = accum;
          res.last         = (accum == 10'd0);
        end else if (cnt < CNT_W'(LENGTH_DIGITS)) begin
          if (!stopped && is_digit) begin
            accum_nxt = sat;
          end else begin
            stopped_nxt = 1'b1;
          end
          cnt_nxt = cnt + 1'b1;
        end else if (is_open) begin
          mode_nxt      = MODE_LEN;
          accum_nxt     = '0;
          cnt_nxt       = '0;
          stopped_nxt   = 1'b0;
          remaining_nxt = '0;
        end else begin
          mode_nxt = MODE_HUNT;
        end
      end
      MODE_SKIP: begin
        mode_nxt = (remaining != 10'd0) ? MODE_DATA : MODE_HUNT;
      end
      MODE_DATA: begin
        res_valid        = 1'b1;
        res.result_kind  = KIND_PAYLOAD;
        res.payload      = data_byte;
        res.frame_length = accum;
        res.last         = (remaining <= 10'd1);
        remaining_nxt    = rem_dec;
        if (rem_dec == 10'd0) begin
          mode_nxt = MODE_HUNT;
        end
      end
      default: begin
        mode_nxt = MODE_HUNT;
      end
    endcase
  end
endmodule

### src/ascii_length_prefixed_deframer.sv
`timescale 1ns / 1ps

// Deframer for byte streams of the form [nnn][payload].
// in_ch carries one raw byte per word; out_ch carries one result per word:
// a frame-start word (result_kind 0) with the decoded decimal length, then
// one word per payload byte (result_kind 1) with last set on the final one.
// A zero-length frame gives only the start word, with last set.
// Throughput: one input word per clock unless out_ch stalls. Each byte
// goes through one pass of the frame decoder; a byte that yields a result
// lands in the output register and shows on out_ch in the next cycle.
// in_ch.ready is high whenever the output register is empty or is being
// drained in the same cycle; a stalled receiver holds the result word and,
// after that, stops the input side.
// Reset (rst_n low, synchronous) puts the decoder back to hunting for '['
// and empties the output register.
// LENGTH_DIGITS sets how many length characters may stand between brackets.
module ascii_length_prefixed_deframer #(
  parameter int LENGTH_DIGITS = 3
) (
  input logic       clk,
  input logic       rst_n,
  alpd_byte_if.sink in_ch,
  alpd_res_if.source out_ch
);
  import alpd_pkg::*;

  localparam int CNT_W = $clog2(LENGTH_DIGITS + 1);

  mode_t            mode_r, mode_nxt;
  logic [9:0]       accum_r, accum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             stopped_r, stopped_nxt;
  logic [9:0]       remaining_r, remaining_nxt;
  logic             res_valid;
  res_t             res;
  logic             out_valid_r;
  res_t             out_r;
  logic             in_take;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  alpd_step #(
    .LENGTH_DIGITS(LENGTH_DIGITS),
    .CNT_W(CNT_W)
  ) u_step (
    .mode(mode_r),
    .accum(accum_r),
    .cnt(cnt_r),
    .stopped(stopped_r),
    .remaining(remaining_r),
    .data_byte(in_ch.data_byte),
    .mode_nxt(mode_nxt),
    .accum_nxt(accum_nxt),
    .cnt_nxt(cnt_nxt),
    .stopped_nxt(stopped_nxt),
    .remaining_nxt(remaining_nxt),
    .res_valid(res_valid),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_HUNT;
      accum_r     <= '0;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        mode_r      <= mode_nxt;
        accum_r     <= accum_nxt;
        cnt_r       <= cnt_nxt;
        stopped_r   <= stopped_nxt;
        remaining_r <= remaining_nxt;
      end
      if (in_ch.ready) begin
        out_valid_r <= in_take && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res_valid && in_ch.ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_r.result_kind;
  assign out_ch.payload      = out_r.payload;
  assign out_ch.frame_length = out_r.frame_length;
  assign out_ch.last         = out_r.last;
endmodule

### src/alpd_checker.sv
`timescale 1ns / 1ps

module alpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_result_kind,
  input logic [7:0] out_payload,
  input logic [9:0] out_frame_length,
  input logic       out_last
);
  import alpd_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_payload) && $stable(out_frame_length) && $stable(out_last))
    else $error("stalled result word changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_start_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_START |-> out_payload == 8'd0)
    else $error("start word carries a payload byte");

  a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_START |->
      out_last == (out_frame_length == 10'd0))
    else $error("start word last flag does not match length");

  a_payload_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PAYLOAD |-> out_frame_length != 10'd0)
    else $error("payload word in a zero-length frame");
endmodule

bind ascii_length_prefixed_deframer alpd_checker u_alpd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_result_kind(out_ch.result_kind),
  .out_payload(out_ch.payload),
  .out_frame_length(out_ch.frame_length),
  .out_last(out_ch.last)
);
